// ----- src/dtq_pkg.sv -----
package dtq_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_CELLS = 16;   // slot numbers are 4 bits wide
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 63;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 3;
  localparam int RANK_W    = 4;
  localparam int CNT_W     = 5;
  localparam int IN_DATA_W = 200;  // 4 + 63 + 63 + 63 = 193, padded to bytes
  localparam int OUT_DATA_W = 72;  // 4 + 1 + 1 + 63 = 69, padded to bytes

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    RK_ADDED     = 3'd0,
    RK_FULL      = 3'd1,
    RK_CANCELLED = 3'd2,
    RK_NOT_ARMED = 3'd3,
    RK_EXPIRED   = 3'd4,
    RK_NONE_DUE  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_ADD,
    CMD_CANCEL,
    CMD_RANK_LOAD,
    CMD_RANK_STEP,
    CMD_REARM,
    CMD_MIN_LOAD,
    CMD_MIN_STEP
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_REARM,
    ST_MLOAD,
    ST_MIN,
    ST_EMIT
  } state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cmd_e  cmd;
    time_t now;
    time_t dl;
    time_t iv;
  } cell_ctrl_t;

  // word handed from one cell to the next around the ring
  typedef struct packed {
    logic  v;
    time_t d;
    slot_t idx;
  } probe_t;

  typedef struct packed {
    logic              armed;
    logic              due;
    logic [RANK_W-1:0] rank;
  } cell_stat_t;

  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

// ----- src/dtq_cell.sv -----
module dtq_cell #(
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtq_pkg::cell_ctrl_t ctrl_i,
  input  logic                sel_i,
  input  dtq_pkg::probe_t     probe_i,
  output dtq_pkg::probe_t     probe_o,
  output dtq_pkg::cell_stat_t stat_o
);

  localparam dtq_pkg::slot_t MY = dtq_pkg::SLOT_W'(IDX);

  logic                       armed_q, armed_d;
  logic                       due_q, due_d;
  logic [dtq_pkg::RANK_W-1:0] rank_q, rank_d;
  dtq_pkg::time_t             dl_q, dl_d;
  dtq_pkg::time_t             iv_q, iv_d;
  dtq_pkg::probe_t            probe_q, probe_d;
  logic                       in_first;
  logic                       in_better;

  // neighbor ahead of us in (deadline, slot) order
  assign in_first  = probe_i.v && ((probe_i.d < dl_q) ||
                     ((probe_i.d == dl_q) && (probe_i.idx < MY)));
  assign in_better = probe_i.v && (!probe_q.v || (probe_i.d < probe_q.d));

  always_comb begin
    armed_d = armed_q;
    due_d   = due_q;
    rank_d  = rank_q;
    dl_d    = dl_q;
    iv_d    = iv_q;
    probe_d = probe_q;
    unique case (ctrl_i.cmd)
      dtq_pkg::CMD_ADD: begin
        if (sel_i) begin
          armed_d = 1'b1;
          dl_d    = ctrl_i.dl;
          iv_d    = ctrl_i.iv;
        end
      end
      dtq_pkg::CMD_CANCEL: begin
        if (sel_i) armed_d = 1'b0;
      end
      dtq_pkg::CMD_RANK_LOAD: begin
        due_d   = armed_q && (dl_q <= ctrl_i.now);
        rank_d  = '0;
        probe_d = '{v: due_d, d: dl_q, idx: MY};
      end
      dtq_pkg::CMD_RANK_STEP: begin
        if (due_q && in_first) rank_d = rank_q + 1'b1;
        probe_d = probe_i;
      end
      dtq_pkg::CMD_REARM: begin
        if (due_q) begin
          if (iv_q != '0) dl_d = dtq_pkg::sat_add(ctrl_i.now, iv_q);
          else armed_d = 1'b0;
        end
      end
      dtq_pkg::CMD_MIN_LOAD: probe_d = '{v: armed_q, d: dl_q, idx: MY};
      dtq_pkg::CMD_MIN_STEP: begin
        if (in_better) probe_d = probe_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      due_q   <= 1'b0;
      rank_q  <= '0;
      probe_q <= '0;
    end else begin
      armed_q <= armed_d;
      due_q   <= due_d;
      rank_q  <= rank_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q <= dl_d;
    iv_q <= iv_d;
  end

  assign probe_o = probe_q;
  assign stat_o  = '{armed: armed_q, due: due_q, rank: rank_q};

endmodule

// ----- src/deadline_timer_queue.sv -----
// Channel  Dir  Bus   tuser                   tdata (low bit up)
// s_axis   in   200b  operation[1:0]          timer_slot, deadline, interval, current_time
// m_axis   out  72b   result_kind[2:0]        slot_number, became_earliest, next_valid,
//                                             next_deadline; tlast = last result of item
//
// One item at a time; a new word is taken only when the sequencer is idle.
// Add and cancel: a min load, then the min pass (N = min(SLOTS, 16) cells) that
// runs the running-minimum word once around the ring of cells.
// Tick: rank pass around the ring, re-arm, min pass, then one result per
// cycle. Output stalls hold the sequencer in its emit step.
// Reset clears armed bits and control; deadlines and intervals are not reset.
module deadline_timer_queue #(
  parameter int SLOTS = dtq_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [3:0] timer_slot, [66:4] deadline, [129:67] interval, [192:130] current_time
  input  logic [dtq_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [1:0] operation
  input  logic [dtq_pkg::OP_W-1:0]        s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [3:0] slot_number, [4] became_earliest, [5] next_valid, [68:6] next_deadline
  output logic [dtq_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // [2:0] result_kind
  output logic [dtq_pkg::KIND_W-1:0]      m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  localparam int NSL  = (SLOTS < dtq_pkg::MAX_CELLS) ? SLOTS : dtq_pkg::MAX_CELLS;
  localparam int STPW = (NSL > 2) ? $clog2(NSL - 1) : 1;
  localparam logic [STPW-1:0] STEP_LAST = STPW'(NSL - 2);

  dtq_pkg::state_e     state_q, state_d;
  dtq_pkg::cell_ctrl_t ctrl;
  dtq_pkg::probe_t     probe [NSL];
  dtq_pkg::cell_stat_t stat  [NSL];
  logic [NSL-1:0]      sel;
  logic [NSL-1:0]      armed_v;
  logic [NSL-1:0]      due_v;
  logic [dtq_pkg::MAX_CELLS-1:0] armed_pad;

  // input word fields
  logic            in_acc;
  dtq_pkg::op_e    in_op;
  dtq_pkg::slot_t  in_slot;
  dtq_pkg::time_t  in_dl, in_iv, in_now;

  // item context
  dtq_pkg::op_e    op_q;
  dtq_pkg::kind_e  kind_q;
  dtq_pkg::slot_t  slot_q;
  logic            early_q;
  dtq_pkg::time_t  now_q;
  logic [STPW-1:0] step_q;
  logic [dtq_pkg::RANK_W-1:0] emit_q;

  // output register
  logic                          ovalid_q;
  dtq_pkg::kind_e                okind_q;
  dtq_pkg::slot_t                oslot_q;
  logic                          oearly_q, onv_q, olast_q;
  dtq_pkg::time_t                ond_q;

  logic            free_found;
  dtq_pkg::slot_t  free_idx;
  logic            cancel_ok;
  logic            early;
  logic [dtq_pkg::CNT_W-1:0] n_due;
  dtq_pkg::slot_t  pick;
  logic            step_done;
  logic            fire;
  logic            emit_last;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op   = dtq_pkg::op_e'(s_axis_tuser_i);
  assign in_slot = s_axis_tdata_i[3:0];
  assign in_dl   = s_axis_tdata_i[66:4];
  assign in_iv   = s_axis_tdata_i[129:67];
  assign in_now  = s_axis_tdata_i[192:130];

  // ring of cells: each takes its word from the cell below it
  for (genvar g = 0; g < NSL; g++) begin : g_cell
    dtq_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sel_i   (sel[g]),
      .probe_i (probe[(g + NSL - 1) % NSL]),
      .probe_o (probe[g]),
      .stat_o  (stat[g])
    );
    assign armed_v[g] = stat[g].armed;
    assign due_v[g]   = stat[g].due;
  end

  always_comb begin
    armed_pad = '0;
    armed_pad[NSL-1:0] = armed_v;
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NSL; i++) begin
      if (!armed_v[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = dtq_pkg::SLOT_W'(i);
      end
    end
  end

  assign cancel_ok = armed_pad[in_slot];
  // probe[0] holds the earliest deadline left by the previous item
  assign early     = !probe[0].v || (in_dl < probe[0].d);

  always_comb begin
    n_due = '0;
    pick  = '0;
    for (int i = 0; i < NSL; i++) begin
      n_due = n_due + dtq_pkg::CNT_W'(due_v[i]);
      if (due_v[i] && (stat[i].rank == emit_q)) pick = pick | dtq_pkg::SLOT_W'(i);
    end
  end

  assign step_done = (step_q == STEP_LAST);
  assign fire      = (state_q == dtq_pkg::ST_EMIT) && (!ovalid_q || m_axis_tready_i);
  assign emit_last = (op_q != dtq_pkg::OP_TICK) || (n_due == '0) ||
                     ({1'b0, emit_q} == n_due - 1'b1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            dtq_pkg::OP_TICK: state_d = dtq_pkg::ST_RANK;
            dtq_pkg::OP_NONE: state_d = dtq_pkg::ST_IDLE;
            default:          state_d = dtq_pkg::ST_MLOAD;
          endcase
        end
      end
      dtq_pkg::ST_RANK:  if (step_done) state_d = dtq_pkg::ST_REARM;
      dtq_pkg::ST_REARM: state_d = dtq_pkg::ST_MLOAD;
      dtq_pkg::ST_MLOAD: state_d = dtq_pkg::ST_MIN;
      dtq_pkg::ST_MIN:   if (step_done) state_d = dtq_pkg::ST_EMIT;
      dtq_pkg::ST_EMIT:  if (fire && emit_last) state_d = dtq_pkg::ST_IDLE;
      default:           state_d = dtq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: cell command and selects
  always_comb begin
    s_axis_tready_o = (state_q == dtq_pkg::ST_IDLE);
    ctrl.cmd = dtq_pkg::CMD_IDLE;
    ctrl.now = (state_q == dtq_pkg::ST_IDLE) ? in_now : now_q;
    ctrl.dl  = in_dl;
    ctrl.iv  = in_iv;
    sel      = '0;
    unique case (state_q)
      dtq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            dtq_pkg::OP_ADD: begin
              if (free_found) ctrl.cmd = dtq_pkg::CMD_ADD;
              for (int i = 0; i < NSL; i++) sel[i] = (free_idx == dtq_pkg::SLOT_W'(i));
            end
            dtq_pkg::OP_CANCEL: begin
              if (cancel_ok) ctrl.cmd = dtq_pkg::CMD_CANCEL;
              for (int i = 0; i < NSL; i++) sel[i] = (in_slot == dtq_pkg::SLOT_W'(i));
            end
            dtq_pkg::OP_TICK: ctrl.cmd = dtq_pkg::CMD_RANK_LOAD;
            default: ;
          endcase
        end
      end
      dtq_pkg::ST_RANK:  ctrl.cmd = dtq_pkg::CMD_RANK_STEP;
      dtq_pkg::ST_REARM: ctrl.cmd = dtq_pkg::CMD_REARM;
      dtq_pkg::ST_MLOAD: ctrl.cmd = dtq_pkg::CMD_MIN_LOAD;
      dtq_pkg::ST_MIN:   ctrl.cmd = dtq_pkg::CMD_MIN_STEP;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dtq_pkg::ST_IDLE;
      step_q   <= '0;
      emit_q   <= '0;
      ovalid_q <= 1'b0;
      op_q     <= dtq_pkg::OP_NONE;
    end else begin
      state_q <= state_d;
      if ((state_q == dtq_pkg::ST_RANK) || (state_q == dtq_pkg::ST_MIN)) begin
        step_q <= step_done ? '0 : step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (fire) emit_q <= emit_last ? '0 : emit_q + 1'b1;
      if (fire) ovalid_q <= 1'b1;
      else if (m_axis_tready_i) ovalid_q <= 1'b0;
      if (in_acc) op_q <= in_op;
    end
  end

  // item context and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q <= in_now;
      if (in_op == dtq_pkg::OP_ADD) begin
        kind_q  <= free_found ? dtq_pkg::RK_ADDED : dtq_pkg::RK_FULL;
        slot_q  <= free_found ? free_idx : '0;
        early_q <= free_found && early;
      end else begin
        kind_q  <= cancel_ok ? dtq_pkg::RK_CANCELLED : dtq_pkg::RK_NOT_ARMED;
        slot_q  <= in_slot;
        early_q <= 1'b0;
      end
    end
    if (fire) begin
      if (op_q == dtq_pkg::OP_TICK) begin
        okind_q  <= (n_due == '0) ? dtq_pkg::RK_NONE_DUE : dtq_pkg::RK_EXPIRED;
        oslot_q  <= pick;
        oearly_q <= 1'b0;
      end else begin
        okind_q  <= kind_q;
        oslot_q  <= slot_q;
        oearly_q <= early_q;
      end
      onv_q   <= probe[0].v;
      ond_q   <= probe[0].v ? probe[0].d : '0;
      olast_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {3'b000, ond_q, onv_q, oearly_q, oslot_q};

endmodule

// ----- src/dtq_checker.sv -----
module dtq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [dtq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [dtq_pkg::KIND_W-1:0]     m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= dtq_pkg::KIND_W'(dtq_pkg::RK_NONE_DUE))
    else $error("result kind out of range");

  a_early_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |->
      m_axis_tuser_o == dtq_pkg::KIND_W'(dtq_pkg::RK_ADDED))
    else $error("earliest flag on a result other than an add");

  a_next_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[5] |-> m_axis_tdata_o[68:6] == '0)
    else $error("next deadline set without next valid");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != dtq_pkg::KIND_W'(dtq_pkg::RK_EXPIRED)) |->
      m_axis_tlast_o)
    else $error("single-result item without last");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
